>>> hw/rtl/dpbf_pkg.sv
`timescale 1ns / 1ps
// Package for the dynamic point box filter: table size, opcodes, register map,
// and the packed transaction types of the input and result channels. No dependencies.
package dpbf_pkg;

  localparam int unsigned MAX_BOXES = 16;
  localparam int unsigned IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned MARGIN_W     = 20;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 20'd307;
  localparam logic [CFG_ADDR_W-3:0] REG_BOX_MARGIN = '0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         slot;
    logic               slot_valid;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic [22:0]        size_x;
    logic [22:0]        size_y;
    logic [22:0]        size_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic               moving;
  } out_item_t;

endpackage

>>> hw/rtl/dynamic_point_box_filter_unit.sv
`timescale 1ns / 1ps
// A point result passes the stage 1, stage 2, stage 3 and output registers after its input is accepted.
// Throughput: one transaction per cycle unless out_ready stalls; stage 1 reads and
// writes the box table, so every point sees exactly the writes and clears before it.
// Reset (rst_n low, synchronous): all slots invalid, pipeline empty, box_margin = 307.
// Depends on dpbf_pkg.
module dynamic_point_box_filter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dpbf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dpbf_pkg::out_item_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dpbf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dpbf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dpbf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned NB = dpbf_pkg::MAX_BOXES;

  // configuration
  logic [dpbf_pkg::MARGIN_W-1:0] margin_r;
  logic                          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[dpbf_pkg::CFG_ADDR_W-1:2] == dpbf_pkg::REG_BOX_MARGIN);
  assign prdata  = cfg_sel ? dpbf_pkg::CFG_DATA_W'(margin_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= dpbf_pkg::MARGIN_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      margin_r <= pwdata[dpbf_pkg::MARGIN_W-1:0];
    end
  end

  // box table
  logic [NB-1:0]      tab_valid_r;
  logic signed [23:0] tab_cx_r [NB];
  logic signed [23:0] tab_cy_r [NB];
  logic signed [23:0] tab_cz_r [NB];
  logic [22:0]        tab_sx_r [NB];
  logic [22:0]        tab_sy_r [NB];
  logic [22:0]        tab_sz_r [NB];

  // pipeline control
  logic                v1_r, v2_r, v3_r, out_valid_r;
  dpbf_pkg::in_item_t  s1_r;
  logic                s1_go, s2_go, s3_go;
  logic                en1, en2, en3, out_en;
  logic                tab_wr, tab_clr;
  logic [dpbf_pkg::IDX_W-1:0] wr_idx;

  assign out_en = !out_valid_r || out_ready;
  assign s3_go  = v3_r && out_en;
  assign en3    = !v3_r || s3_go;
  assign s2_go  = v2_r && en3;
  assign en2    = !v2_r || s2_go;
  assign s1_go  = v1_r && ((s1_r.opcode != dpbf_pkg::OP_POINT) || en2);
  assign en1    = !v1_r || s1_go;
  assign in_ready = en1;

  assign tab_wr  = s1_go && (s1_r.opcode == dpbf_pkg::OP_WRITE) &&
                   (32'(s1_r.slot) < 32'(NB));
  assign tab_clr = s1_go && (s1_r.opcode == dpbf_pkg::OP_CLEAR);
  assign wr_idx  = dpbf_pkg::IDX_W'(s1_r.slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_valid_r <= '0;
    end else if (tab_clr) begin
      tab_valid_r <= '0;
    end else if (tab_wr) begin
      tab_valid_r[wr_idx] <= s1_r.slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_cx_r[wr_idx] <= s1_r.coord_x;
      tab_cy_r[wr_idx] <= s1_r.coord_y;
      tab_cz_r[wr_idx] <= s1_r.coord_z;
      tab_sx_r[wr_idx] <= s1_r.size_x;
      tab_sy_r[wr_idx] <= s1_r.size_y;
      tab_sz_r[wr_idx] <= s1_r.size_z;
    end
  end

  // stage 1: hold the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= in_data;
    end
  end

  // stage 1 -> 2: per-box differences and thresholds
  logic signed [24:0] dx_nxt [NB];
  logic signed [24:0] dy_nxt [NB];
  logic signed [24:0] dz_nxt [NB];
  logic [23:0]        tx_nxt [NB];
  logic [23:0]        ty_nxt [NB];
  logic [23:0]        tz_nxt [NB];
  logic [23:0]        margin2;

  assign margin2 = {3'b000, margin_r, 1'b0};

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      dx_nxt[i] = $signed({s1_r.coord_x[23], s1_r.coord_x}) -
                  $signed({tab_cx_r[i][23], tab_cx_r[i]});
      dy_nxt[i] = $signed({s1_r.coord_y[23], s1_r.coord_y}) -
                  $signed({tab_cy_r[i][23], tab_cy_r[i]});
      dz_nxt[i] = $signed({s1_r.coord_z[23], s1_r.coord_z}) -
                  $signed({tab_cz_r[i][23], tab_cz_r[i]});
      tx_nxt[i] = {1'b0, tab_sx_r[i]} + margin2;
      ty_nxt[i] = {1'b0, tab_sy_r[i]} + margin2;
      tz_nxt[i] = {1'b0, tab_sz_r[i]} + margin2;
    end
  end

  logic signed [24:0] dx_r [NB];
  logic signed [24:0] dy_r [NB];
  logic signed [24:0] dz_r [NB];
  logic [23:0]        tx_r [NB];
  logic [23:0]        ty_r [NB];
  logic [23:0]        tz_r [NB];
  logic [NB-1:0]      valid2_r;
  logic signed [23:0] px2_r, py2_r, pz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r && (s1_r.opcode == dpbf_pkg::OP_POINT);
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r && (s1_r.opcode == dpbf_pkg::OP_POINT)) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      dz_r     <= dz_nxt;
      tx_r     <= tx_nxt;
      ty_r     <= ty_nxt;
      tz_r     <= tz_nxt;
      valid2_r <= tab_valid_r;
      px2_r    <= s1_r.coord_x;
      py2_r    <= s1_r.coord_y;
      pz2_r    <= s1_r.coord_z;
    end
  end

  // stage 2 -> 3: 2*|d| < size + 2*margin on each axis, per box
  function automatic logic axis_in(input logic signed [24:0] d, input logic [23:0] thr);
    logic [24:0] mag;
    mag = d[24] ? (~d + 25'd1) : d;
    return {mag, 1'b0} < {2'b00, thr};
  endfunction

  logic [NB-1:0]      hit_nxt;
  logic [NB-1:0]      hit_r;
  logic signed [23:0] px3_r, py3_r, pz3_r;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      hit_nxt[i] = valid2_r[i] && axis_in(dx_r[i], tx_r[i]) &&
                   axis_in(dy_r[i], ty_r[i]) && axis_in(dz_r[i], tz_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      hit_r <= hit_nxt;
      px3_r <= px2_r;
      py3_r <= py2_r;
      pz3_r <= pz2_r;
    end
  end

  // stage 3 -> output: reduce box hits
  dpbf_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_data_r.point_x <= px3_r;
      out_data_r.point_y <= py3_r;
      out_data_r.point_z <= pz3_r;
      out_data_r.moving  <= |hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/dpbf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for dynamic_point_box_filter_unit, bound into that module.
// Depends on dpbf_pkg.
module dpbf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input dpbf_pkg::in_item_t               in_data,
  input logic                             out_valid,
  input logic                             out_ready,
  input dpbf_pkg::out_item_t              out_data,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [dpbf_pkg::CFG_ADDR_W-1:0]  paddr,
  input logic [dpbf_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [dpbf_pkg::CFG_DATA_W-1:0]  prdata,
  input logic                             pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_margin_reset: assert property (@(posedge clk)
    !rst_n |=> (paddr[dpbf_pkg::CFG_ADDR_W-1:2] != dpbf_pkg::REG_BOX_MARGIN) ||
               (prdata == dpbf_pkg::CFG_DATA_W'(dpbf_pkg::MARGIN_RESET)))
    else $error("box_margin not at reset value");

  a_margin_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready &&
    (paddr[dpbf_pkg::CFG_ADDR_W-1:2] == dpbf_pkg::REG_BOX_MARGIN)
    |=> (paddr[dpbf_pkg::CFG_ADDR_W-1:2] != dpbf_pkg::REG_BOX_MARGIN) ||
        (prdata == dpbf_pkg::CFG_DATA_W'($past(pwdata[dpbf_pkg::MARGIN_W-1:0]))))
    else $error("box_margin readback mismatch");

endmodule

bind dynamic_point_box_filter_unit dpbf_checker u_dpbf_checker (.*);
